>>> sv/tts_pkg.sv
// shared types, constants and codes of the tick task scheduler
package tts_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_IDX_W       = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int ID_W            = 8;
   localparam int WORD_W          = 32;
   localparam int STATUS_W        = 4;
   localparam int HELD_W          = 5;

   typedef enum logic [1:0] {
      REQ_SET      = 2'd0,
      REQ_DELETE   = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_DISPATCH = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NULL      = 4'd0,
      ST_UPDATED   = 4'd1,
      ST_ADDED     = 4'd2,
      ST_FULL      = 4'd3,
      ST_REMOVED   = 4'd4,
      ST_NOT_FOUND = 4'd5,
      ST_RUN       = 4'd6,
      ST_NONE      = 4'd7,
      ST_TICK      = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      WR_NONE = 3'd0,
      WR_SET  = 3'd1,
      WR_ADD  = 3'd2,
      WR_TICK = 3'd3,
      WR_RUN  = 3'd4,
      WR_MOVE = 3'd5
   } wr_op_type;

   typedef enum logic [1:0] {
      RES_NONE  = 2'd0,
      RES_ENTRY = 2'd1,
      RES_REQ   = 2'd2,
      RES_ZERO  = 2'd3
   } res_op_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [WORD_W-1:0] delay;
      logic [WORD_W-1:0] period;
      logic              ready;
   } entry_type;

   typedef struct packed {
      logic       accept;
      logic       rd_idx;
      logic       rd_next;
      logic       rd_tail;
      logic       idx_inc;
      wr_op_type  wr_op;
      logic       cnt_inc;
      logic       cnt_dec;
      res_op_type res_op;
      status_type code;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         id_zero;
      logic         scan_end;
      logic         next_ok;
      logic         hit;
      logic         ent_ready;
      logic         period_zero;
      logic         at_tail;
      logic         full;
      logic         res_full;
      logic         res_empty;
      logic         out_free;
      logic         emit_last;
   } dp_flags_type;

endpackage

>>> sv/tick_task_scheduler.sv
// tick task scheduler top level: controller plus table datapath
// dispatch responses leave one per cycle while rsp_ready does not hold the output register
// throughput: one request at a time; the table scan reads one entry per cycle on the table
// memory read port, which sets the rate, though each task run during a dispatch pauses the scan
// reset clears the entry count and tick counter; table contents stay undefined, no clear pass
module tick_task_scheduler #(
   parameter int MAX_ENTRIES = tts_pkg::MAX_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [tts_pkg::ID_W-1:0]      req_task_id,
   input  logic [tts_pkg::WORD_W-1:0]    req_first_delay,
   input  logic [tts_pkg::WORD_W-1:0]    req_repeat_period,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tts_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tts_pkg::ID_W-1:0]      rsp_run_id,
   output logic [tts_pkg::WORD_W-1:0]    rsp_ticks_now,
   output logic [tts_pkg::HELD_W-1:0]    rsp_tasks_held,
   output logic                          rsp_last
);
   import tts_pkg::*;

   dp_cmd_type   cmd;
   dp_flags_type flags;

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   tts_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_task_id       (req_task_id),
      .req_first_delay   (req_first_delay),
      .req_repeat_period (req_repeat_period),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_run_id        (rsp_run_id),
      .rsp_ticks_now     (rsp_ticks_now),
      .rsp_tasks_held    (rsp_tasks_held),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .flags             (flags)
   );

endmodule

>>> sv/tts_ctrl.sv
// controller state machine sequencing table scans for each request
module tts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tts_pkg::dp_flags_type flags,
   output tts_pkg::dp_cmd_type   cmd
);
   import tts_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EVAL = 5'b00100,
      S_MOVE = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.wr_op  = WR_NONE;
      cmd.res_op = RES_NONE;
      cmd.code   = ST_NULL;
      state_in   = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            case (flags.kind)
               REQ_SET: begin
                  if (flags.id_zero) begin
                     cmd.res_op = RES_ZERO;
                     cmd.code   = ST_NULL;
                     state_in   = S_EMIT;
                  end else if (flags.scan_end) begin
                     cmd.res_op = RES_REQ;
                     if (flags.full) begin
                        cmd.code = ST_FULL;
                     end else begin
                        cmd.code    = ST_ADDED;
                        cmd.wr_op   = WR_ADD;
                        cmd.cnt_inc = 1'b1;
                     end
                     state_in = S_EMIT;
                  end else begin
                     cmd.rd_idx = 1'b1;
                     state_in   = S_EVAL;
                  end
               end
               REQ_DELETE: begin
                  if (flags.scan_end) begin
                     cmd.res_op = RES_REQ;
                     cmd.code   = ST_NOT_FOUND;
                     state_in   = S_EMIT;
                  end else begin
                     cmd.rd_idx = 1'b1;
                     state_in   = S_EVAL;
                  end
               end
               REQ_TICK: begin
                  if (flags.scan_end) begin
                     cmd.res_op = RES_ZERO;
                     cmd.code   = ST_TICK;
                     state_in   = S_EMIT;
                  end else begin
                     cmd.rd_idx = 1'b1;
                     state_in   = S_EVAL;
                  end
               end
               default: begin
                  if (flags.scan_end || flags.res_full) begin
                     if (flags.res_empty) begin
                        cmd.res_op = RES_ZERO;
                        cmd.code   = ST_NONE;
                     end
                     state_in = S_EMIT;
                  end else begin
                     cmd.rd_idx = 1'b1;
                     state_in   = S_EVAL;
                  end
               end
            endcase
         end
         S_EVAL: begin
            case (flags.kind)
               REQ_SET: begin
                  if (flags.hit) begin
                     cmd.wr_op  = WR_SET;
                     cmd.res_op = RES_REQ;
                     cmd.code   = ST_UPDATED;
                     state_in   = S_EMIT;
                  end else if (flags.next_ok) begin
                     cmd.rd_next = 1'b1;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end
               end
               REQ_DELETE: begin
                  if (flags.hit) begin
                     cmd.res_op = RES_REQ;
                     cmd.code   = ST_REMOVED;
                     if (flags.at_tail) begin
                        cmd.cnt_dec = 1'b1;
                        state_in    = S_EMIT;
                     end else begin
                        cmd.rd_tail = 1'b1;
                        state_in    = S_MOVE;
                     end
                  end else if (flags.next_ok) begin
                     cmd.rd_next = 1'b1;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end
               end
               REQ_TICK: begin
                  cmd.wr_op = WR_TICK;
                  if (flags.next_ok) begin
                     cmd.rd_next = 1'b1;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end
               end
               default: begin
                  if (flags.ent_ready) begin
                     cmd.res_op = RES_ENTRY;
                     cmd.code   = ST_RUN;
                     if (flags.period_zero && !flags.at_tail) begin
                        cmd.rd_tail = 1'b1;
                        state_in    = S_MOVE;
                     end else begin
                        if (flags.period_zero) begin
                           cmd.cnt_dec = 1'b1;
                        end else begin
                           cmd.wr_op = WR_RUN;
                        end
                        cmd.idx_inc = 1'b1;
                        state_in    = S_READ;
                     end
                  end else if (flags.next_ok) begin
                     cmd.rd_next = 1'b1;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end
               end
            endcase
         end
         S_MOVE: begin
            cmd.wr_op   = WR_MOVE;
            cmd.cnt_dec = 1'b1;
            if (flags.kind == REQ_DELETE) begin
               state_in = S_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_READ;
            end
         end
         S_EMIT: begin
            if (flags.out_free) begin
               cmd.emit = 1'b1;
               if (flags.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> sv/tts_dpath.sv
// datapath: task table memory, counters, result buffer and output register
module tts_dpath #(
   parameter int MAX_ENTRIES = tts_pkg::MAX_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_type,
   input  logic [tts_pkg::ID_W-1:0]      req_task_id,
   input  logic [tts_pkg::WORD_W-1:0]    req_first_delay,
   input  logic [tts_pkg::WORD_W-1:0]    req_repeat_period,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [tts_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tts_pkg::ID_W-1:0]      rsp_run_id,
   output logic [tts_pkg::WORD_W-1:0]    rsp_ticks_now,
   output logic [tts_pkg::HELD_W-1:0]    rsp_tasks_held,
   output logic                          rsp_last,
   input  tts_pkg::dp_cmd_type           cmd,
   output tts_pkg::dp_flags_type         flags
);
   import tts_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic            rd_en, wr_en;
   logic [AW-1:0]   rd_addr, wr_addr;

   req_kind_type      kind_ff;
   logic [ID_W-1:0]   id_ff;
   logic [WORD_W-1:0] delay_ff, period_ff;
   logic [CNT_W-1:0]  count_ff, idx_ff, idx_nx, tail;
   logic [CNT_W:0]    idx_ext_nx;
   logic [WORD_W-1:0] tick_ff;

   logic [ID_W-1:0]      res_buf [MAX_RESULTS];
   logic [RES_CNT_W-1:0] res_n_ff, emit_ff, emit_nx;
   status_type           status_ff;
   logic [ID_W-1:0]      push_id;

   logic                 rsp_valid_ff, rsp_last_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]      rsp_run_id_ff;
   logic [WORD_W-1:0]    rsp_ticks_ff;
   logic [HELD_W-1:0]    rsp_held_ff;
   logic [CNT_W+HELD_W-1:0] count_wide;

   assign idx_nx     = idx_ff + CNT_W'(1);
   assign idx_ext_nx = {1'b0, idx_ff} + (CNT_W+1)'(1);
   assign tail       = count_ff - CNT_W'(1);
   assign emit_nx    = emit_ff + RES_CNT_W'(1);
   assign count_wide = {{HELD_W{1'b0}}, count_ff};

   // status toward the controller
   always_comb begin
      flags.kind        = kind_ff;
      flags.id_zero     = (id_ff == '0);
      flags.scan_end    = (idx_ff >= count_ff);
      flags.next_ok     = (idx_ext_nx < {1'b0, count_ff});
      flags.hit         = (rd_data_ff.id == id_ff);
      flags.ent_ready   = rd_data_ff.ready;
      flags.period_zero = (rd_data_ff.period == '0);
      flags.at_tail     = (idx_ext_nx == {1'b0, count_ff});
      flags.full        = (count_ff == CNT_W'(MAX_ENTRIES));
      flags.res_full    = (res_n_ff == RES_CNT_W'(MAX_RESULTS));
      flags.res_empty   = (res_n_ff == '0);
      flags.out_free    = !rsp_valid_ff || rsp_ready;
      flags.emit_last   = (emit_nx == res_n_ff);
   end

   // table port control
   always_comb begin
      rd_en   = cmd.rd_idx || cmd.rd_next || cmd.rd_tail;
      rd_addr = idx_ff[AW-1:0];
      if (cmd.rd_next) begin
         rd_addr = idx_nx[AW-1:0];
      end else if (cmd.rd_tail) begin
         rd_addr = tail[AW-1:0];
      end
      wr_en   = (cmd.wr_op != WR_NONE);
      wr_addr = (cmd.wr_op == WR_ADD) ? count_ff[AW-1:0] : idx_ff[AW-1:0];
      wr_data = rd_data_ff;
      case (cmd.wr_op)
         WR_SET, WR_ADD: begin
            wr_data.id     = id_ff;
            wr_data.delay  = delay_ff;
            wr_data.period = period_ff;
            wr_data.ready  = 1'b0;
         end
         WR_TICK: begin
            if (rd_data_ff.delay == '0) begin
               wr_data.ready = 1'b1;
            end else begin
               wr_data.delay = rd_data_ff.delay - WORD_W'(1);
            end
         end
         WR_RUN: begin
            wr_data.ready = 1'b0;
            if (rd_data_ff.delay == '0) begin
               wr_data.delay = rd_data_ff.period - WORD_W'(1);
            end
         end
         default: begin
            wr_data = rd_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      case (cmd.res_op)
         RES_ENTRY: push_id = rd_data_ff.id;
         RES_REQ:   push_id = id_ff;
         default:   push_id = '0;
      endcase
   end

   // request latch and result buffer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_kind_type'(req_type);
         id_ff     <= req_task_id;
         delay_ff  <= req_first_delay;
         period_ff <= req_repeat_period;
      end
      if (cmd.res_op != RES_NONE) begin
         res_buf[res_n_ff[RES_IDX_W-1:0]] <= push_id;
         status_ff                        <= cmd.code;
      end
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_run_id_ff <= res_buf[emit_ff[RES_IDX_W-1:0]];
         rsp_ticks_ff  <= tick_ff;
         rsp_held_ff   <= count_wide[HELD_W-1:0];
         rsp_last_ff   <= flags.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tick_ff      <= '0;
         idx_ff       <= '0;
         res_n_ff     <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            idx_ff   <= '0;
            res_n_ff <= '0;
            emit_ff  <= '0;
            if (req_kind_type'(req_type) == REQ_TICK) begin
               tick_ff <= tick_ff + WORD_W'(1);
            end
         end else begin
            if (cmd.rd_next || cmd.idx_inc) begin
               idx_ff <= idx_nx;
            end
            if (cmd.res_op != RES_NONE) begin
               res_n_ff <= res_n_ff + RES_CNT_W'(1);
            end
            if (cmd.emit) begin
               emit_ff <= emit_nx;
            end
         end
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= tail;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_run_id     = rsp_run_id_ff;
   assign rsp_ticks_now  = rsp_ticks_ff;
   assign rsp_tasks_held = rsp_held_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
